### design/cmds_pkg.sv
// Shared types, constants and small decode functions for the clock and
// matrix display scanner. No dependencies.
package cmds_pkg;

    // Field widths
    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned DIGIT_CNT = 4;
    localparam int unsigned ROW_CNT   = 8;
    localparam int unsigned DIG_IDX_W = $clog2(DIGIT_CNT);
    localparam int unsigned ROW_IDX_W = $clog2(ROW_CNT);
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MIN_W     = 6;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned SHIFT_W   = 4;
    localparam int unsigned IN_W      = 8;
    localparam int unsigned OUT_W     = 48;
    localparam int unsigned CFG_IDX_W = 3;

    // Reset values
    localparam logic [PERIOD_W-1:0] BLINK_RST  = 16'd100;
    localparam logic [PERIOD_W-1:0] SCAN_RST   = 16'd25;
    localparam logic [PERIOD_W-1:0] SECOND_RST = 16'd100;
    localparam logic [PERIOD_W-1:0] ROW_RST    = 16'd10;
    localparam logic [PERIOD_W-1:0] SCROLL_RST = 16'd80;
    localparam logic [HOUR_W-1:0]   HOUR_RST   = 5'd15;
    localparam logic [MIN_W-1:0]    MIN_RST    = 6'd8;
    localparam logic [MIN_W-1:0]    SEC_RST    = 6'd50;
    localparam logic [SHIFT_W-1:0]  SHIFT_MIN  = 4'h9;   // -7
    localparam logic [SHIFT_W-1:0]  SHIFT_MAX  = 4'h6;
    localparam logic [SHIFT_W-1:0]  SHIFT_NEG8 = 4'h8;
    localparam logic [MIN_W-1:0]    MIN_LIMIT  = 6'd60;
    localparam logic [HOUR_W-1:0]   HOUR_LIMIT = 5'd24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLINK  = 3'd0,
        CFG_SCAN   = 3'd1,
        CFG_SECOND = 3'd2,
        CFG_ROW    = 3'd3,
        CFG_SCROLL = 3'd4
    } t_cfg_idx;

    typedef logic [7:0] t_row;

    // Active-low segment code of one decimal digit, all lit above nine
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // One row of the letter-A glyph
    function automatic t_row glyph_row(input logic [ROW_IDX_W-1:0] r);
        t_row g;
        case (r)
            3'd0:          g = 8'h18;
            3'd1:          g = 8'h3C;
            3'd2, 3'd3:    g = 8'h66;
            3'd4, 3'd5:    g = 8'h7E;
            default:       g = 8'h66;
        endcase
        return g;
    endfunction

    // Tens digit of a value below 64, by comparison
    function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] v);
        logic [3:0] t;
        if      (v >= 6'd60) t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // Units digit of a value below 64
    function automatic logic [3:0] units_of(input logic [MIN_W-1:0] v);
        logic [6:0] tens10;
        logic [6:0] diff;
        tens10 = 7'(tens_of(v)) * 7'd10;
        diff   = {1'b0, v} - tens10;
        return diff[3:0];
    endfunction

endpackage

### design/clock_and_matrix_display_scanner.sv
// Top level of the clock and matrix display scanner: tick timers, clock,
// digit and row scan, glyph scroll and the result register. Uses cmds_pkg.
//
// Each accepted word with bit 0 set is one timer tick; the block returns one
// word of pin levels and clock time per accepted word. It takes one word per
// clock cycle: all timer, clock and scan updates are a single pass of short
// logic from the state registers into the result register, and a word is
// taken whenever the result register is empty or being emptied in the same
// cycle. A result appears in the cycle after its word is taken. Period
// registers are written through the configuration channel, which is always
// ready; a new period takes effect at that timer's next reload. Segments and
// enables are active low and stay at zero until their first scan event.
module clock_and_matrix_display_scanner
    import cmds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick word
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_W-1:0]      i_s_tdata,   // [0] tick, [7:1] zero
    // result word
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,   // [3:0] digit_enables, [10:4] segments,
                                              // [11] colon_dot, [12] red_led,
                                              // [20:13] row_enables, [28:21] column_bits,
                                              // [33:29] hours, [39:34] minutes,
                                              // [45:40] seconds, [47:46] zero
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data
);

    // Period registers
    logic [PERIOD_W-1:0] r_blink_per, r_scan_per, r_sec_per, r_row_per, r_scroll_per;
    // Timers
    logic [PERIOD_W-1:0] r_blink_t, r_scan_t, r_sec_t, r_row_t, r_scroll_t;
    logic [PERIOD_W-1:0] n_blink_t, n_scan_t, n_sec_t, n_row_t, n_scroll_t;
    // Clock and scan state
    logic [HOUR_W-1:0]    r_hour, n_hour;
    logic [MIN_W-1:0]     r_min, n_min, r_sec, n_sec;
    logic [DIG_IDX_W-1:0] r_dig_idx, n_dig_idx;
    logic [ROW_IDX_W-1:0] r_row_idx, n_row_idx;
    logic [SHIFT_W-1:0]   r_shift, n_shift;
    t_row                 r_pattern [ROW_CNT];
    t_row                 n_pattern [ROW_CNT];
    // Pin levels
    logic [DIGIT_CNT-1:0] r_dig_en, n_dig_en;
    logic [SEG_W-1:0]     r_seg, n_seg;
    logic                 r_dot, n_dot, r_red, n_red;
    logic [ROW_CNT-1:0]   r_row_en, n_row_en;
    t_row                 r_col, n_col;
    // Result register
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out;

    logic s_accept, tick;
    logic blink_fire, scan_fire, sec_fire, row_fire, scroll_fire;
    logic [3:0] digit_val;
    logic [MIN_W-1:0] sec_inc, min_inc;
    logic [HOUR_W-1:0] hour_inc;
    logic [4:0] right_amt;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign tick        = s_accept && i_s_tdata[0];

    // Timer fire and reload
    assign blink_fire  = r_blink_t  <= 16'd1;
    assign scan_fire   = r_scan_t   <= 16'd1;
    assign sec_fire    = r_sec_t    <= 16'd1;
    assign row_fire    = r_row_t    <= 16'd1;
    assign scroll_fire = r_scroll_t <= 16'd1;

    always_comb begin
        n_blink_t  = r_blink_t;
        n_scan_t   = r_scan_t;
        n_sec_t    = r_sec_t;
        n_row_t    = r_row_t;
        n_scroll_t = r_scroll_t;
        if (tick) begin
            n_blink_t  = blink_fire  ? r_blink_per  : r_blink_t  - 16'd1;
            n_scan_t   = scan_fire   ? r_scan_per   : r_scan_t   - 16'd1;
            n_sec_t    = sec_fire    ? r_sec_per    : r_sec_t    - 16'd1;
            n_row_t    = row_fire    ? r_row_per    : r_row_t    - 16'd1;
            n_scroll_t = scroll_fire ? r_scroll_per : r_scroll_t - 16'd1;
        end
    end

    // Blink: toggle red LED and colon dot
    always_comb begin
        n_dot = r_dot;
        n_red = r_red;
        if (tick && blink_fire) begin
            n_dot = !r_dot;
            n_red = !r_red;
        end
    end

    // Digit scan, from the clock as it was before this tick
    always_comb begin
        case (r_dig_idx)
            2'd0:    digit_val = tens_of({1'b0, r_hour});
            2'd1:    digit_val = units_of({1'b0, r_hour});
            2'd2:    digit_val = tens_of(r_min);
            default: digit_val = units_of(r_min);
        endcase
        n_dig_en  = r_dig_en;
        n_seg     = r_seg;
        n_dig_idx = r_dig_idx;
        if (tick && scan_fire) begin
            n_dig_en  = ~(DIGIT_CNT'(1) << r_dig_idx);
            n_seg     = seg_code(digit_val);
            n_dig_idx = r_dig_idx + DIG_IDX_W'(1);
        end
    end

    // Clock: seconds, minutes, hours with rollover
    always_comb begin
        sec_inc  = r_sec + 6'd1;
        min_inc  = r_min;
        hour_inc = r_hour;
        if (sec_inc >= MIN_LIMIT) begin
            sec_inc = '0;
            min_inc = r_min + 6'd1;
        end
        if (min_inc >= MIN_LIMIT) begin
            min_inc  = '0;
            hour_inc = r_hour + 5'd1;
        end
        if (hour_inc >= HOUR_LIMIT) begin
            hour_inc = '0;
        end
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        if (tick && sec_fire) begin
            n_sec  = sec_inc;
            n_min  = min_inc;
            n_hour = hour_inc;
        end
    end

    // Row scan, from the pattern as it was before this tick
    always_comb begin
        n_row_en  = r_row_en;
        n_col     = r_col;
        n_row_idx = r_row_idx;
        if (tick && row_fire) begin
            n_row_en  = ~(ROW_CNT'(1) << r_row_idx);
            n_col     = r_pattern[r_row_idx];
            n_row_idx = r_row_idx + ROW_IDX_W'(1);
        end
    end

    // Scroll: refill rows with the shifted, inverted glyph and step the shift
    assign right_amt = 5'd16 - {1'b0, r_shift};

    always_comb begin
        logic [15:0] wide;
        t_row        shifted;
        wide    = '0;
        shifted = '0;
        n_shift = r_shift;
        for (int i = 0; i < ROW_CNT; i++) begin
            n_pattern[i] = r_pattern[i];
        end
        if (tick && scroll_fire) begin
            for (int i = 0; i < ROW_CNT; i++) begin
                wide = {8'h00, glyph_row(ROW_IDX_W'(i))};
                if (!r_shift[SHIFT_W-1]) begin
                    wide = wide << r_shift;
                end else begin
                    wide = wide >> right_amt;
                end
                shifted      = wide[7:0];
                n_pattern[i] = ~shifted;
            end
            if (r_shift == SHIFT_MAX || r_shift == SHIFT_NEG8) begin
                n_shift = SHIFT_MIN;
            end else begin
                n_shift = r_shift + SHIFT_W'(1);
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_t  <= BLINK_RST;
            r_scan_t   <= SCAN_RST;
            r_sec_t    <= SECOND_RST;
            r_row_t    <= ROW_RST;
            r_scroll_t <= SCROLL_RST;
            r_hour     <= HOUR_RST;
            r_min      <= MIN_RST;
            r_sec      <= SEC_RST;
            r_dig_idx  <= '0;
            r_row_idx  <= '0;
            r_shift    <= SHIFT_MIN;
            for (int i = 0; i < ROW_CNT; i++) begin
                r_pattern[i] <= '0;
            end
            r_dig_en   <= '0;
            r_seg      <= '0;
            r_dot      <= 1'b0;
            r_red      <= 1'b0;
            r_row_en   <= '0;
            r_col      <= '0;
        end else begin
            r_blink_t  <= n_blink_t;
            r_scan_t   <= n_scan_t;
            r_sec_t    <= n_sec_t;
            r_row_t    <= n_row_t;
            r_scroll_t <= n_scroll_t;
            r_hour     <= n_hour;
            r_min      <= n_min;
            r_sec      <= n_sec;
            r_dig_idx  <= n_dig_idx;
            r_row_idx  <= n_row_idx;
            r_shift    <= n_shift;
            for (int i = 0; i < ROW_CNT; i++) begin
                r_pattern[i] <= n_pattern[i];
            end
            r_dig_en   <= n_dig_en;
            r_seg      <= n_seg;
            r_dot      <= n_dot;
            r_red      <= n_red;
            r_row_en   <= n_row_en;
            r_col      <= n_col;
        end
    end

    // Period registers, written through the configuration channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_per  <= BLINK_RST;
            r_scan_per   <= SCAN_RST;
            r_sec_per    <= SECOND_RST;
            r_row_per    <= ROW_RST;
            r_scroll_per <= SCROLL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BLINK:  r_blink_per  <= i_cfg_data;
                CFG_SCAN:   r_scan_per   <= i_cfg_data;
                CFG_SECOND: r_sec_per    <= i_cfg_data;
                CFG_ROW:    r_row_per    <= i_cfg_data;
                CFG_SCROLL: r_scroll_per <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= {2'b00, n_sec, n_min, n_hour, n_col, n_row_en,
                      n_red, n_dot, n_seg, n_dig_en};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // Checks
    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_m_tvalid)
        else $error("accepted tick produced no result word");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift != SHIFT_NEG8)
        else $error("glyph shift reached minus eight");

    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row_en == '0) || ($countones(~r_row_en) == 1))
        else $error("row enables not active-low one-hot");

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour < HOUR_LIMIT) && (r_min < MIN_LIMIT) && (r_sec < MIN_LIMIT))
        else $error("clock out of range");

    a_colon_follows_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot == r_red)
        else $error("colon dot and red LED diverged");

endmodule
